>>> rtl/core/mlr_pkg.sv
package mlr_pkg;

  // default coordinate width
  localparam int COORD_BITS_DEF = 12;

  // extra headroom of the decision variable over a coordinate
  localparam int DEC_EXTRA = 4;

  // request kinds carried on the input tuser
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_STEP  = 1'b1;

  typedef enum logic [1:0] {
    SLOPE_SHALLOW_UP   = 2'd0,
    SLOPE_SHALLOW_DOWN = 2'd1,
    SLOPE_STEEP_UP     = 2'd2,
    SLOPE_STEEP_DOWN   = 2'd3
  } slope_e;

  typedef struct packed {
    logic   busy;
    slope_e slope;
  } ctrl_t;

  localparam ctrl_t CTRL_IDLE = '{busy: 1'b0, slope: SLOPE_SHALLOW_UP};

endpackage

>>> rtl/core/midpoint_line_rasterizer.sv
// channel   dir  tdata (low bit up)                          tuser       tlast
// s_axis    in   start_x, start_y, end_x_in, end_y_in        req_type    -
// m_axis    out  pixel_x, pixel_y                            no_pixel    is_last
//
// one beat in, one beat out; a new request can be taken every cycle while m_axis is not stalled
// a request passes the input register, then one add and compare into the result register
// rst_ni clears the line state to idle, with no line in progress
// a stall on m_axis holds the result; one more request waits in the input register
module midpoint_line_rasterizer #(
  parameter int COORD_BITS  = mlr_pkg::COORD_BITS_DEF,
  localparam int InDataW    = ((4 * COORD_BITS + 7) / 8) * 8,
  localparam int OutDataW   = ((2 * COORD_BITS + 7) / 8) * 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [InDataW-1:0]   s_axis_tdata_i,   // start_x, start_y, end_x_in, end_y_in
  input  logic                 s_axis_tuser_i,   // req_type
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [OutDataW-1:0]  m_axis_tdata_o,   // pixel_x, pixel_y
  output logic                 m_axis_tuser_o,   // no_pixel
  output logic                 m_axis_tlast_o    // is_last
);
  import mlr_pkg::*;

  localparam int DecBits = COORD_BITS + DEC_EXTRA;

  // input register
  logic                         in_valid_q;
  logic                         in_req_q;
  logic signed [COORD_BITS-1:0] in_ax_q, in_ay_q, in_bx_q, in_by_q;

  // line state
  ctrl_t                        ctrl_q, ctrl_d;
  logic signed [COORD_BITS-1:0] cur_x_q, cur_y_q, stop_x_q, stop_y_q;
  logic signed [COORD_BITS-1:0] cur_x_d, cur_y_d, stop_x_d, stop_y_d;
  logic signed [DecBits-1:0]    decision_q, inc_first_q, inc_second_q;
  logic signed [DecBits-1:0]    decision_d, inc_first_d, inc_second_d;

  // result register
  logic                         out_valid_q;
  logic signed [COORD_BITS-1:0] pix_x_q, pix_y_q, pix_x_d, pix_y_d;
  logic                         last_q, last_d, nopix_q, nopix_d;

  logic s_fire, advance;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_fire) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_req_q <= s_axis_tuser_i;
      in_ax_q  <= s_axis_tdata_i[COORD_BITS-1:0];
      in_ay_q  <= s_axis_tdata_i[2*COORD_BITS-1:COORD_BITS];
      in_bx_q  <= s_axis_tdata_i[3*COORD_BITS-1:2*COORD_BITS];
      in_by_q  <= s_axis_tdata_i[4*COORD_BITS-1:3*COORD_BITS];
    end
  end

  mlr_step #(
    .COORD_BITS (COORD_BITS)
  ) u_step (
    .req_type_i   (in_req_q),
    .start_x_i    (in_ax_q),
    .start_y_i    (in_ay_q),
    .end_x_i      (in_bx_q),
    .end_y_i      (in_by_q),
    .ctrl_i       (ctrl_q),
    .cur_x_i      (cur_x_q),
    .cur_y_i      (cur_y_q),
    .stop_x_i     (stop_x_q),
    .stop_y_i     (stop_y_q),
    .decision_i   (decision_q),
    .inc_first_i  (inc_first_q),
    .inc_second_i (inc_second_q),
    .ctrl_o       (ctrl_d),
    .cur_x_o      (cur_x_d),
    .cur_y_o      (cur_y_d),
    .stop_x_o     (stop_x_d),
    .stop_y_o     (stop_y_d),
    .decision_o   (decision_d),
    .inc_first_o  (inc_first_d),
    .inc_second_o (inc_second_d),
    .pixel_x_o    (pix_x_d),
    .pixel_y_o    (pix_y_d),
    .is_last_o    (last_d),
    .no_pixel_o   (nopix_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q       <= CTRL_IDLE;
      cur_x_q      <= '0;
      cur_y_q      <= '0;
      stop_x_q     <= '0;
      stop_y_q     <= '0;
      decision_q   <= '0;
      inc_first_q  <= '0;
      inc_second_q <= '0;
    end else if (advance) begin
      ctrl_q       <= ctrl_d;
      cur_x_q      <= cur_x_d;
      cur_y_q      <= cur_y_d;
      stop_x_q     <= stop_x_d;
      stop_y_q     <= stop_y_d;
      decision_q   <= decision_d;
      inc_first_q  <= inc_first_d;
      inc_second_q <= inc_second_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      pix_x_q <= pix_x_d;
      pix_y_q <= pix_y_d;
      last_q  <= last_d;
      nopix_q <= nopix_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OutDataW'({pix_y_q, pix_x_q});
  assign m_axis_tuser_o  = nopix_q;
  assign m_axis_tlast_o  = last_q;

  // an idle step reports the origin and never closes a line
  a_nopix_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && nopix_q |-> !last_q && pix_x_q == '0 && pix_y_q == '0)
    else $error("no-pixel beat carries pixel data");

  // a step request never starts a line
  a_step_no_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_req_q == REQ_STEP |=> !$rose(ctrl_q.busy))
    else $error("step request set busy");

  // the final pixel leaves the block idle
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && last_d |=> !ctrl_q.busy)
    else $error("busy after last pixel");

  // a request in the input register is held until it moves on
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q)
    else $error("pending request dropped");

  // every request that advances shows up as a result beat
  a_advance_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("result lost");

endmodule

>>> rtl/core/mlr_step.sv
module mlr_step #(
  parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF,
  localparam int DecBits   = COORD_BITS + mlr_pkg::DEC_EXTRA
) (
  input  logic                          req_type_i,
  input  logic signed [COORD_BITS-1:0]  start_x_i,
  input  logic signed [COORD_BITS-1:0]  start_y_i,
  input  logic signed [COORD_BITS-1:0]  end_x_i,
  input  logic signed [COORD_BITS-1:0]  end_y_i,
  input  mlr_pkg::ctrl_t                ctrl_i,
  input  logic signed [COORD_BITS-1:0]  cur_x_i,
  input  logic signed [COORD_BITS-1:0]  cur_y_i,
  input  logic signed [COORD_BITS-1:0]  stop_x_i,
  input  logic signed [COORD_BITS-1:0]  stop_y_i,
  input  logic signed [DecBits-1:0]     decision_i,
  input  logic signed [DecBits-1:0]     inc_first_i,
  input  logic signed [DecBits-1:0]     inc_second_i,
  output mlr_pkg::ctrl_t                ctrl_o,
  output logic signed [COORD_BITS-1:0]  cur_x_o,
  output logic signed [COORD_BITS-1:0]  cur_y_o,
  output logic signed [COORD_BITS-1:0]  stop_x_o,
  output logic signed [COORD_BITS-1:0]  stop_y_o,
  output logic signed [DecBits-1:0]     decision_o,
  output logic signed [DecBits-1:0]     inc_first_o,
  output logic signed [DecBits-1:0]     inc_second_o,
  output logic signed [COORD_BITS-1:0]  pixel_x_o,
  output logic signed [COORD_BITS-1:0]  pixel_y_o,
  output logic                          is_last_o,
  output logic                          no_pixel_o
);
  import mlr_pkg::*;

  localparam int ExtBits = DecBits - COORD_BITS;

  logic                         swap;
  logic signed [COORD_BITS-1:0] x0, y0, x1, y1;
  logic signed [DecBits-1:0]    dx, dy, dx2, dy2, neg_dy;
  logic                         d_pos;
  logic signed [COORD_BITS-1:0] nx, ny;
  logic                         minor_move;
  logic                         step_last;

  // order endpoints left to right and take the deltas at decision width
  always_comb begin
    swap   = end_x_i < start_x_i;
    x0     = swap ? end_x_i   : start_x_i;
    y0     = swap ? end_y_i   : start_y_i;
    x1     = swap ? start_x_i : end_x_i;
    y1     = swap ? start_y_i : end_y_i;
    dx     = {{ExtBits{x1[COORD_BITS-1]}}, x1} - {{ExtBits{x0[COORD_BITS-1]}}, x0};
    dy     = {{ExtBits{y1[COORD_BITS-1]}}, y1} - {{ExtBits{y0[COORD_BITS-1]}}, y0};
    dx2    = dx <<< 1;
    dy2    = dy <<< 1;
    neg_dy = -dy;
  end

  // one pixel advance: the major axis always moves, the minor one on the decision sign
  always_comb begin
    d_pos = decision_i > 0;
    nx    = cur_x_i;
    ny    = cur_y_i;
    case (ctrl_i.slope)
      SLOPE_SHALLOW_UP: begin
        minor_move = !d_pos;
        nx         = cur_x_i + 1'b1;
        ny         = minor_move ? cur_y_i + 1'b1 : cur_y_i;
        step_last  = nx >= stop_x_i;
      end
      SLOPE_SHALLOW_DOWN: begin
        minor_move = d_pos;
        nx         = cur_x_i + 1'b1;
        ny         = minor_move ? cur_y_i - 1'b1 : cur_y_i;
        step_last  = nx >= stop_x_i;
      end
      SLOPE_STEEP_UP: begin
        minor_move = d_pos;
        ny         = cur_y_i + 1'b1;
        nx         = minor_move ? cur_x_i + 1'b1 : cur_x_i;
        step_last  = ny >= stop_y_i;
      end
      default: begin
        minor_move = !d_pos;
        ny         = cur_y_i - 1'b1;
        nx         = minor_move ? cur_x_i + 1'b1 : cur_x_i;
        step_last  = ny <= stop_y_i;
      end
    endcase
  end

  always_comb begin
    ctrl_o       = ctrl_i;
    cur_x_o      = cur_x_i;
    cur_y_o      = cur_y_i;
    stop_x_o     = stop_x_i;
    stop_y_o     = stop_y_i;
    decision_o   = decision_i;
    inc_first_o  = inc_first_i;
    inc_second_o = inc_second_i;
    pixel_x_o    = '0;
    pixel_y_o    = '0;
    is_last_o    = 1'b0;
    no_pixel_o   = 1'b0;

    if (req_type_i == REQ_START) begin
      cur_x_o  = x0;
      cur_y_o  = y0;
      stop_x_o = x1;
      stop_y_o = y1;
      if (!dy[DecBits-1] && dy <= dx) begin
        ctrl_o.slope = SLOPE_SHALLOW_UP;
        decision_o   = dx - dy2;
        inc_first_o  = -dy2;
        inc_second_o = dx2 - dy2;
        is_last_o    = dx == '0;
      end else if (dy[DecBits-1] && neg_dy <= dx) begin
        ctrl_o.slope = SLOPE_SHALLOW_DOWN;
        decision_o   = -dy2 - dx;
        inc_first_o  = -dy2 - dx2;
        inc_second_o = -dy2;
      end else if (!dy[DecBits-1]) begin
        ctrl_o.slope = SLOPE_STEEP_UP;
        decision_o   = dx2 - dy;
        inc_first_o  = dx2 - dy2;
        inc_second_o = dx2;
      end else begin
        ctrl_o.slope = SLOPE_STEEP_DOWN;
        decision_o   = neg_dy - dx2;
        inc_first_o  = -dx2;
        inc_second_o = -dy2 - dx2;
      end
      ctrl_o.busy = !is_last_o;
      pixel_x_o   = x0;
      pixel_y_o   = y0;
    end else if (!ctrl_i.busy) begin
      no_pixel_o = 1'b1;
    end else begin
      cur_x_o     = nx;
      cur_y_o     = ny;
      decision_o  = decision_i + (d_pos ? inc_first_i : inc_second_i);
      ctrl_o.busy = !step_last;
      pixel_x_o   = nx;
      pixel_y_o   = ny;
      is_last_o   = step_last;
    end
  end

endmodule

>>> tb/tb.sv
module tb;
  import mlr_pkg::*;

  localparam int CB    = COORD_BITS_DEF;
  localparam int IN_W  = ((4 * CB + 7) / 8) * 8;
  localparam int OUT_W = ((2 * CB + 7) / 8) * 8;
  localparam int RANDOM_ITEMS = 1550;

  typedef struct packed {
    logic [CB-1:0] x;
    logic [CB-1:0] y;
    logic          last;
    logic          none;
  } pixel_t;

  class line_tracer;
    pixel_t pending_pixels[$];
    int     errors;
    int     cur_x, cur_y, stop_x, stop_y;
    int     decision, inc_first, inc_second;
    slope_e slope;
    bit     line_active;

    function new();
      errors = 0;
      cur_x = 0; cur_y = 0; stop_x = 0; stop_y = 0;
      decision = 0; inc_first = 0; inc_second = 0;
      slope = SLOPE_SHALLOW_UP;
      line_active = 1'b0;
    endfunction

    // the decision variable and its increments wrap at CB+4 bits
    function int dec_wrap(int v);
      logic signed [CB+DEC_EXTRA-1:0] t;
      t = v[CB+DEC_EXTRA-1:0];
      return t;
    endfunction

    function void note_request(logic req, logic [IN_W-1:0] data);
      int     ax, ay, bx, by, dx, dy, t;
      logic   last;
      pixel_t p;
      last = 1'b0;
      if (req == REQ_START) begin
        ax = $signed(data[CB-1:0]);
        ay = $signed(data[2*CB-1:CB]);
        bx = $signed(data[3*CB-1:2*CB]);
        by = $signed(data[4*CB-1:3*CB]);
        if (bx < ax) begin
          t = ax; ax = bx; bx = t;
          t = ay; ay = by; by = t;
        end
        dx = bx - ax;
        dy = by - ay;
        cur_x = ax; cur_y = ay; stop_x = bx; stop_y = by;
        if (dy >= 0 && dy <= dx) begin
          slope = SLOPE_SHALLOW_UP;
          decision = dec_wrap(dx - 2 * dy);
          inc_first = dec_wrap(-2 * dy);
          inc_second = dec_wrap(2 * (dx - dy));
          last = (dx == 0);
        end else if (dy < 0 && -dy <= dx) begin
          slope = SLOPE_SHALLOW_DOWN;
          decision = dec_wrap(-2 * dy - dx);
          inc_first = dec_wrap(-2 * dy - 2 * dx);
          inc_second = dec_wrap(-2 * dy);
        end else if (dy > 0) begin
          slope = SLOPE_STEEP_UP;
          decision = dec_wrap(2 * dx - dy);
          inc_first = dec_wrap(2 * (dx - dy));
          inc_second = dec_wrap(2 * dx);
        end else begin
          slope = SLOPE_STEEP_DOWN;
          decision = dec_wrap(-dy - 2 * dx);
          inc_first = dec_wrap(-2 * dx);
          inc_second = dec_wrap(2 * (-dy - dx));
        end
        line_active = !last;
      end else if (!line_active) begin
        p = '{x: '0, y: '0, last: 1'b0, none: 1'b1};
        pending_pixels.push_back(p);
        return;
      end else begin
        case (slope)
          SLOPE_SHALLOW_UP: begin
            if (decision <= 0) begin
              cur_y++;
              decision = dec_wrap(decision + inc_second);
            end else decision = dec_wrap(decision + inc_first);
            cur_x++;
            last = (cur_x >= stop_x);
          end
          SLOPE_SHALLOW_DOWN: begin
            if (decision > 0) begin
              cur_y--;
              decision = dec_wrap(decision + inc_first);
            end else decision = dec_wrap(decision + inc_second);
            cur_x++;
            last = (cur_x >= stop_x);
          end
          SLOPE_STEEP_UP: begin
            if (decision > 0) begin
              cur_x++;
              decision = dec_wrap(decision + inc_first);
            end else decision = dec_wrap(decision + inc_second);
            cur_y++;
            last = (cur_y >= stop_y);
          end
          default: begin
            if (decision <= 0) begin
              cur_x++;
              decision = dec_wrap(decision + inc_second);
            end else decision = dec_wrap(decision + inc_first);
            cur_y--;
            last = (cur_y <= stop_y);
          end
        endcase
        if (last) line_active = 1'b0;
      end
      p = '{x: CB'(cur_x), y: CB'(cur_y), last: last, none: 1'b0};
      pending_pixels.push_back(p);
    endfunction

    function void check_pixel(logic [OUT_W-1:0] data, logic tuser, logic tlast);
      pixel_t want;
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected pixel beat x=%h y=%h last=%b none=%b", $time,
                 data[CB-1:0], data[2*CB-1:CB], tlast, tuser);
        errors++;
        return;
      end
      want = pending_pixels.pop_front();
      if (data[CB-1:0] !== want.x) begin
        $display("%0t: pixel_x expected %h actual %h", $time, want.x, data[CB-1:0]);
        errors++;
      end
      if (data[2*CB-1:CB] !== want.y) begin
        $display("%0t: pixel_y expected %h actual %h", $time, want.y, data[2*CB-1:CB]);
        errors++;
      end
      if (tlast !== want.last) begin
        $display("%0t: is_last expected %b actual %b", $time, want.last, tlast);
        errors++;
      end
      if (tuser !== want.none) begin
        $display("%0t: no_pixel expected %b actual %b", $time, want.none, tuser);
        errors++;
      end
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             s_axis_tvalid_i;
  logic             s_axis_tready_o;
  logic [IN_W-1:0]  s_axis_tdata_i;
  logic             s_axis_tuser_i;
  logic             m_axis_tvalid_o;
  logic             m_axis_tready_i;
  logic [OUT_W-1:0] m_axis_tdata_o;
  logic             m_axis_tuser_o;
  logic             m_axis_tlast_o;

  line_tracer tracer;
  int         sent_count;
  int         pixel_count;
  int         hold_left;
  bit         hold_done;

  midpoint_line_rasterizer #(.COORD_BITS(CB)) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  function automatic logic [IN_W-1:0] pack_line(int ax, int ay, int bx, int by);
    logic [IN_W-1:0] d;
    d = '0;
    d[CB-1:0]      = CB'(ax);
    d[2*CB-1:CB]   = CB'(ay);
    d[3*CB-1:2*CB] = CB'(bx);
    d[4*CB-1:3*CB] = CB'(by);
    return d;
  endfunction

  function automatic logic [IN_W-1:0] noise_bits();
    return IN_W'({$urandom, $urandom});
  endfunction

  function automatic int rand_coord();
    return int'($urandom_range(0, 4095)) - 2048;
  endfunction

  function automatic int near(int base, int span);
    int v;
    v = base + int'($urandom_range(0, 2 * span)) - span;
    if (v < -2048) v = -2048;
    if (v > 2047) v = 2047;
    return v;
  endfunction

  task automatic send_request(logic req, logic [IN_W-1:0] data);
    // no gaps on the input side for a stretch in the middle of the run
    while (!(sent_count >= 600 && sent_count < 900) && $urandom_range(0, 99) < 34) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= req;
    s_axis_tdata_i  <= data;
    do @(posedge clk_i); while (!s_axis_tready_o);
    tracer.note_request(req, data);
    sent_count++;
  endtask

  task automatic draw_line(int ax, int ay, int bx, int by, int max_steps);
    int n;
    n = 0;
    send_request(REQ_START, pack_line(ax, ay, bx, by));
    while (tracer.line_active && n < max_steps) begin
      send_request(REQ_STEP, noise_bits());
      n++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        tracer.check_pixel(m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
        pixel_count++;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else if (pixel_count >= 300 && !hold_done) begin
        // long back-pressure so the block fills and drops its tready
        hold_done = 1'b1;
        hold_left = 40;
        m_axis_tready_i <= 1'b0;
      end else if (pixel_count >= 650 && pixel_count < 950) begin
        m_axis_tready_i <= 1'b1;
      end else begin
        m_axis_tready_i <= ($urandom_range(0, 99) >= 34);
      end
    end
  end

  initial begin
    #(12 * 200000);
    $display("tb: errors");
    $finish;
  end

  initial begin
    int r, ax, ay, n;
    tracer = new();
    sent_count = 0;
    pixel_count = 0;
    hold_left = 0;
    hold_done = 1'b0;
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    s_axis_tuser_i = REQ_START;
    m_axis_tready_i = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(REQ_STEP, '1);
    draw_line(2047, -2048, 2047, -2048, 8);
    draw_line(2, 1, 0, 0, 8);
    draw_line(0, 0, 2, -2, 8);
    draw_line(0, 0, 1, 2, 8);
    draw_line(0, 2, 0, 0, 8);
    send_request(REQ_STEP, '0);
    // full-range starts, cut short by the next start
    draw_line(-2048, -2048, 2047, 2047, 2);
    draw_line(2047, -2048, -2048, 2047, 1);

    n = sent_count + RANDOM_ITEMS;
    while (sent_count < n) begin
      r = $urandom_range(0, 99);
      ax = rand_coord();
      ay = rand_coord();
      if (r < 3) begin
        draw_line(ax, ay, near(ax, 250), near(ay, 250), 1000);
      end else if (r < 68) begin
        draw_line(ax, ay, near(ax, 12), near(ay, 12), 1000);
      end else if (r < 80) begin
        draw_line(ax, ay, near(ax, 12), near(ay, 12), $urandom_range(0, 4));
      end else if (r < 90) begin
        repeat ($urandom_range(1, 3)) send_request(REQ_STEP, noise_bits());
      end else begin
        draw_line(ax, ay, rand_coord(), rand_coord(), $urandom_range(0, 4));
      end
    end

    s_axis_tvalid_i <= 1'b0;
    while (tracer.pending_pixels.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (tracer.errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
